### design/i2cm_pkg.sv
// shared types and constants for the i2c master transaction engine
// no dependencies; imported by i2cm_out_queue, i2cm_engine and the top module
package i2cm_pkg;

  localparam int BUF_DEPTH = 16;
  localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int FILL_W    = $clog2(BUF_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS = 2'd1;

  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd10;
  localparam logic [15:0] PHASE_TICKS_RST = 16'd15;
  localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_ST3,
    PH_TXL0, PH_TXL1, PH_TXH0, PH_TXH1,
    PH_AKL0, PH_AKL1, PH_AKW, PH_AKH,
    PH_RXL0, PH_RXL1, PH_RXH0, PH_RXH1,
    PH_MAL0, PH_MAL1, PH_MAH0, PH_MAH1,
    PH_SP0, PH_SP1, PH_SP2
  } phase_t;

  typedef struct packed {
    logic [1:0] op;
    logic       sda_in;
    logic [7:0] wr_byte;
    logic [6:0] dev_addr;
    logic [4:0] tx_count;
    logic [7:0] rx_count;
    logic       hold_bus;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       rd_last;
    logic       done_res;
    logic       failed;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  ack_timeout;
    logic [15:0] phase_ticks;
  } cfg_t;

endpackage

### design/i2cm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module i2cm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/i2cm_out_queue.sv
// two-entry result queue between the engine and the output channel
// depends on i2cm_pkg
module i2cm_out_queue import i2cm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_data,
  output logic      full,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  out_item_t  slot0;
  out_item_t  slot1;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_item  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end else if (pop && !push) begin
      slot0 <= slot1;
    end else if (pop && push) begin
      if (count == 2'd1) begin
        slot0 <= push_data;
      end else begin
        slot0 <= slot1;
        slot1 <= push_data;
      end
    end
  end

endmodule

### design/i2cm_engine.sv
// bus sequencer: phase state, counters, and the write byte buffer in ram
// depends on i2cm_pkg and i2cm_ram
module i2cm_engine import i2cm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  phase_t              phase, phase_next;
  logic [15:0]         phase_counter, phase_counter_next;
  logic [3:0]          bit_counter, bit_counter_next;
  logic [7:0]          shift_reg, shift_reg_next;
  logic [7:0]          byte_counter, byte_counter_next;
  logic [7:0]          ack_wait, ack_wait_next;
  logic [FILL_W-1:0]   fill_count, fill_count_next;
  logic [6:0]          addr, addr_next;
  logic [4:0]          ntx, ntx_next;
  logic [7:0]          nrx, nrx_next;
  logic                hold, hold_next;
  logic                reading, reading_next;
  logic                fail, fail_next;
  logic [1:0]          lines, lines_next;

  logic                ram_we;
  logic [7:0]          ram_rdata;
  logic                do_enter;
  logic [16:0]         pc_inc;
  logic [15:0]         len;
  logic [8:0]          ntx_min;
  logic                last_cur;
  logic                last_new;

  // byte_counter is stable long before an acknowledge ends, so the registered
  // read of the next write byte is always ready in time
  i2cm_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH), .AW(BUF_AW)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_count[BUF_AW-1:0]),
    .wdata (item.wr_byte),
    .raddr (byte_counter[BUF_AW-1:0]),
    .rdata (ram_rdata)
  );

  function automatic logic [1:0] phase_lines(phase_t ph, logic bit_v, logic mack,
                                             logic [1:0] cur);
    logic [1:0] l;
    l = cur;
    case (ph)
      PH_ST0:                               l = 2'b01;
      PH_ST1:                               l = 2'b11;
      PH_ST2:                               l = 2'b10;
      PH_ST3:                               l = 2'b00;
      PH_TXL0, PH_TXL1:                     l = {1'b0, bit_v};
      PH_TXH0, PH_TXH1:                     l = {1'b1, bit_v};
      PH_AKL0, PH_AKL1, PH_RXL0, PH_RXL1:   l = 2'b01;
      PH_AKW, PH_AKH, PH_RXH0, PH_RXH1:     l = 2'b11;
      PH_MAL0, PH_MAL1:                     l = {1'b0, mack};
      PH_MAH0, PH_MAH1:                     l = {1'b1, mack};
      PH_SP0:                               l = 2'b00;
      PH_SP1:                               l = 2'b10;
      PH_SP2:                               l = 2'b11;
      default:                              l = cur;
    endcase
    return l;
  endfunction

  assign last_cur = ({1'b0, byte_counter} + 9'd1) >= {1'b0, nrx};
  assign pc_inc   = {1'b0, phase_counter} + 17'd1;
  assign len      = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
  assign ntx_min  = ({4'd0, item.tx_count} > 9'(fill_count)) ? 9'(fill_count)
                                                             : {4'd0, item.tx_count};

  always_comb begin
    phase_next         = phase;
    phase_counter_next = phase_counter;
    bit_counter_next   = bit_counter;
    shift_reg_next     = shift_reg;
    byte_counter_next  = byte_counter;
    ack_wait_next      = ack_wait;
    fill_count_next    = fill_count;
    addr_next          = addr;
    ntx_next           = ntx;
    nrx_next           = nrx;
    hold_next          = hold;
    reading_next       = reading;
    fail_next          = fail;
    lines_next         = lines;
    ram_we             = 1'b0;
    do_enter           = 1'b0;
    result             = '0;
    last_new           = 1'b0;

    if (accept) begin
      case (item.op)
        OP_LOAD: begin
          if (phase == PH_IDLE && 9'(fill_count) < 9'(BUF_DEPTH)) begin
            ram_we          = 1'b1;
            fill_count_next = fill_count + FILL_W'(1);
          end
        end
        OP_BEGIN: begin
          if (phase == PH_IDLE) begin
            addr_next         = item.dev_addr;
            ntx_next          = ntx_min[4:0];
            nrx_next          = item.rx_count;
            hold_next         = item.hold_bus;
            reading_next      = 1'b0;
            fail_next         = 1'b0;
            byte_counter_next = 8'd0;
            ack_wait_next     = 8'd0;
            bit_counter_next  = 4'd0;
            if (ntx_min == 9'd0 && item.rx_count != 8'd0) begin
              reading_next   = 1'b1;
              shift_reg_next = {item.dev_addr, 1'b1};
            end else begin
              shift_reg_next = {item.dev_addr, 1'b0};
            end
            phase_next = PH_ST0;
            do_enter   = 1'b1;
          end
        end
        OP_TICK: begin
          if (phase == PH_AKW) begin
            if (!item.sda_in) begin
              phase_next = PH_AKH;
              do_enter   = 1'b1;
            end else if (ack_wait >= cfg.ack_timeout) begin
              fail_next  = 1'b1;
              phase_next = PH_SP0;
              do_enter   = 1'b1;
            end else begin
              ack_wait_next = ack_wait + 8'd1;
            end
          end else if (phase != PH_IDLE) begin
            if (pc_inc < {1'b0, len}) begin
              phase_counter_next = pc_inc[15:0];
            end else begin
              if (phase == PH_RXH0) begin
                shift_reg_next = {shift_reg[6:0], item.sda_in};
              end
              do_enter = 1'b1;
              case (phase)
                PH_ST0:  phase_next = PH_ST1;
                PH_ST1:  phase_next = PH_ST2;
                PH_ST2:  phase_next = PH_ST3;
                PH_ST3:  phase_next = PH_TXL0;
                PH_TXL0: phase_next = PH_TXL1;
                PH_TXL1: phase_next = PH_TXH0;
                PH_TXH0: phase_next = PH_TXH1;
                PH_TXH1: begin
                  bit_counter_next = bit_counter + 4'd1;
                  shift_reg_next   = {shift_reg[6:0], 1'b0};
                  phase_next = (bit_counter_next >= BITS_PER_BYTE) ? PH_AKL0 : PH_TXL0;
                end
                PH_AKL0: phase_next = PH_AKL1;
                PH_AKL1: phase_next = PH_AKW;
                PH_AKH: begin
                  if (reading) begin
                    byte_counter_next = 8'd0;
                    bit_counter_next  = 4'd0;
                    shift_reg_next    = 8'd0;
                    phase_next        = PH_RXL0;
                  end else if ({3'd0, byte_counter} < {6'd0, ntx} &&
                               {3'd0, byte_counter} < 11'(BUF_DEPTH)) begin
                    shift_reg_next    = ram_rdata;
                    byte_counter_next = byte_counter + 8'd1;
                    bit_counter_next  = 4'd0;
                    phase_next        = PH_TXL0;
                  end else if (nrx != 8'd0) begin
                    reading_next     = 1'b1;
                    shift_reg_next   = {addr, 1'b1};
                    bit_counter_next = 4'd0;
                    phase_next       = PH_ST0;
                  end else if (hold) begin
                    // held bus: scl low, sda released
                    do_enter           = 1'b0;
                    result.done_res    = 1'b1;
                    result.failed      = fail;
                    phase_next         = PH_IDLE;
                    phase_counter_next = 16'd0;
                    lines_next         = 2'b01;
                    fill_count_next    = '0;
                  end else begin
                    phase_next = PH_SP0;
                  end
                end
                PH_RXL0: phase_next = PH_RXL1;
                PH_RXL1: phase_next = PH_RXH0;
                PH_RXH0: phase_next = PH_RXH1;
                PH_RXH1: begin
                  bit_counter_next = bit_counter + 4'd1;
                  if (bit_counter_next >= BITS_PER_BYTE) begin
                    result.rd_valid = 1'b1;
                    result.rd_byte  = shift_reg;
                    result.rd_last  = last_cur;
                    phase_next      = PH_MAL0;
                  end else begin
                    phase_next = PH_RXL0;
                  end
                end
                PH_MAL0: phase_next = PH_MAL1;
                PH_MAL1: phase_next = PH_MAH0;
                PH_MAH0: phase_next = PH_MAH1;
                PH_MAH1: begin
                  if (last_cur) begin
                    phase_next = PH_SP0;
                  end else begin
                    byte_counter_next = byte_counter + 8'd1;
                    bit_counter_next  = 4'd0;
                    shift_reg_next    = 8'd0;
                    phase_next        = PH_RXL0;
                  end
                end
                PH_SP0: phase_next = PH_SP1;
                PH_SP1: phase_next = PH_SP2;
                PH_SP2: begin
                  do_enter           = 1'b0;
                  result.done_res    = 1'b1;
                  result.failed      = fail;
                  phase_next         = PH_IDLE;
                  phase_counter_next = 16'd0;
                  lines_next         = 2'b11;
                  fill_count_next    = '0;
                end
                default: begin
                  do_enter   = 1'b0;
                  phase_next = PH_IDLE;
                end
              endcase
            end
          end
        end
        default: ;
      endcase

      // entering a phase restarts its timer and sets the bus lines
      if (do_enter) begin
        phase_counter_next = 16'd0;
        if (phase_next == PH_AKL0) begin
          ack_wait_next = 8'd0;
        end
        last_new   = ({1'b0, byte_counter_next} + 9'd1) >= {1'b0, nrx_next};
        lines_next = phase_lines(phase_next, shift_reg_next[7], last_new, lines);
      end

      result.scl_level = lines_next[1];
      result.sda_level = lines_next[0];
      result.busy_res  = (phase_next != PH_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_counter <= 16'd0;
      bit_counter   <= 4'd0;
      shift_reg     <= 8'd0;
      byte_counter  <= 8'd0;
      ack_wait      <= 8'd0;
      fill_count    <= '0;
      addr          <= 7'd0;
      ntx           <= 5'd0;
      nrx           <= 8'd0;
      hold          <= 1'b0;
      reading       <= 1'b0;
      fail          <= 1'b0;
      lines         <= 2'b11;
    end else begin
      phase         <= phase_next;
      phase_counter <= phase_counter_next;
      bit_counter   <= bit_counter_next;
      shift_reg     <= shift_reg_next;
      byte_counter  <= byte_counter_next;
      ack_wait      <= ack_wait_next;
      fill_count    <= fill_count_next;
      addr          <= addr_next;
      ntx           <= ntx_next;
      nrx           <= nrx_next;
      hold          <= hold_next;
      reading       <= reading_next;
      fail          <= fail_next;
      lines         <= lines_next;
    end
  end

endmodule

### design/i2c_master_transaction_engine_top.sv
// each result is registered in the result queue before it appears on the output
// throughput: one item per cycle; the sequencer updates all state in the cycle
//   of the transfer and the two-entry result queue keeps input open while a
//   result waits; input stalls only when both queue entries are occupied
// reset: synchronous, clears the sequencer to idle with both lines released,
//   ack_timeout 10, phase_ticks 15; write buffer ram contents undefined until loaded
module i2c_master_transaction_engine_top import i2cm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // item channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  out_item_t result;
  logic      accept;
  logic      q_full;

  // configuration registers are always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ack_timeout <= ACK_TIMEOUT_RST;
      cfg.phase_ticks <= PHASE_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ACK_TIMEOUT: cfg.ack_timeout <= cfg_data[7:0];
        REG_PHASE_TICKS: cfg.phase_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // an item transfer can happen whenever the result queue has room
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // sequencer: every accepted item yields exactly one result
  i2cm_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  // result queue decouples the output handshake from item intake
  i2cm_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
